### rtl/assert_macros.svh
// Assertion macros shared by the point set median RTL.
// Expects clk in the scope of each use, and arst_n as well for PSAM_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PSAM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every clock edge, reset included.
`define PSAM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### rtl/psam_pkg.sv
// Package for the point set median block: sizes, status codes and word types.
// No dependencies.
package psam_pkg;

	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 32;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int MIN_SET    = 3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FEW  = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
		logic   last_point;
	} in_word_t;

	typedef struct packed {
		coord_t     median_x;
		coord_t     median_y;
		coord_t     median_z;
		logic [1:0] status;
	} out_word_t;

	typedef struct packed {
		logic clr;
		logic smp_vld;
	} rank_ctl_t;

	typedef struct packed {
		cnt_t lt;
		cnt_t le;
	} rank_cnt_t;

endpackage

### rtl/point_set_axis_median.sv
// Top level of the point set median block: point store, sequencer, output register.
// Depends on psam_pkg, psam_ram, psam_rank and assert_macros.svh.
//
// Usage: points arrive on in_data under in_valid/in_ready, one word per cycle
// while the block is loading. Each point is written to a 256-entry store per
// axis; points beyond the store capacity are dropped and flagged. A word with
// last_point set closes the set and in_ready drops while selection runs.
// Selection walks the store axis by axis with one comparator and one read
// port: each candidate goes through address, capture, a sweep of the set and
// a rank check, and the walk stops at the first candidate of rank n/2. A set
// of fewer than three points skips selection and goes straight to the done
// state, from which its status word is loaded into the output register.
// The result word sits in an output register under out_valid/out_ready; while
// the receiver stalls the next set loads normally, and only the next result
// waits in the done state, with in_ready low, until the held word is taken.
// Reset clears the point count, the overflow flag and the output valid; the
// store contents are left as they are and are never read before being written.
`include "assert_macros.svh"

module point_set_axis_median
	import psam_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_CAND  = 3'd1;
	localparam logic [2:0] S_CLOAD = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_EVAL  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	logic [2:0]        state_q;
	cnt_t              cnt_q;
	logic              ovf_q;
	cnt_t              n_q;
	logic [1:0]        stat_q;
	logic [1:0]        axis_q;
	logic [ADDR_W-1:0] cand_q;
	cnt_t              sweep_q;
	logic              rd_vld_q;
	coord_t            cval_q;
	coord_t            med_q [3];
	logic              out_valid_q;
	out_word_t         out_data_q;

	logic              in_acc;
	logic              full;
	logic              we;
	logic [ADDR_W-1:0] raddr;
	coord_t            rx;
	coord_t            ry;
	coord_t            rz;
	coord_t            rsel;
	logic              iss;
	logic              hit;
	logic              out_load;
	cnt_t              n_new;
	cnt_t              k;
	rank_ctl_t         rctl;
	rank_cnt_t         rcnt;

	assign in_ready = state_q == S_LOAD;
	assign in_acc   = in_valid && in_ready;
	assign full     = cnt_q == CNT_W'(MAX_POINTS);
	assign we       = in_acc && !full;
	assign n_new    = full ? cnt_q : cnt_q + CNT_W'(1);
	assign raddr    = (state_q == S_CAND) ? cand_q : sweep_q[ADDR_W-1:0];
	assign iss      = sweep_q < n_q;
	assign k        = n_q >> 1;
	assign hit      = (rcnt.lt <= k) && (k < rcnt.le);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign rctl.clr     = state_q == S_CLOAD;
	assign rctl.smp_vld = (state_q == S_SWEEP) && rd_vld_q;

	psam_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (in_data.coord_x),
		.raddr (raddr),
		.rdata (rx)
	);

	psam_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (in_data.coord_y),
		.raddr (raddr),
		.rdata (ry)
	);

	psam_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_z (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (in_data.coord_z),
		.raddr (raddr),
		.rdata (rz)
	);

	always_comb begin
		unique case (axis_q)
			AX_X:    rsel = rx;
			AX_Y:    rsel = ry;
			AX_Z:    rsel = rz;
			default: rsel = rx;
		endcase
	end

	psam_rank u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.smp    (rsel),
		.cand   (cval_q),
		.cnt    (rcnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			n_q      <= '0;
			stat_q   <= ST_OK;
			axis_q   <= AX_X;
			cand_q   <= '0;
			sweep_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (!in_data.last_point) begin
							if (full) begin
								ovf_q <= 1'b1;
							end else begin
								cnt_q <= n_new;
							end
						end else begin
							n_q    <= n_new;
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							axis_q <= AX_X;
							cand_q <= '0;
							if (n_new < CNT_W'(MIN_SET)) begin
								stat_q  <= ST_FEW;
								state_q <= S_DONE;
							end else begin
								stat_q  <= (ovf_q || full) ? ST_OVER : ST_OK;
								state_q <= S_CAND;
							end
						end
					end
				end
				S_CAND: begin
					state_q <= S_CLOAD;
				end
				S_CLOAD: begin
					sweep_q  <= '0;
					rd_vld_q <= 1'b0;
					state_q  <= S_SWEEP;
				end
				S_SWEEP: begin
					if (iss) begin
						sweep_q <= sweep_q + CNT_W'(1);
					end
					rd_vld_q <= iss;
					if (!iss && !rd_vld_q) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (hit) begin
						cand_q <= '0;
						if (axis_q == AX_Z) begin
							state_q <= S_DONE;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_CAND;
						end
					end else begin
						cand_q  <= cand_q + ADDR_W'(1);
						state_q <= S_CAND;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Candidate value, per-axis results and the output data word
	always_ff @(posedge clk) begin
		if (state_q == S_CLOAD) begin
			cval_q <= rsel;
		end
		if (in_acc && in_data.last_point) begin
			med_q[0] <= '0;
			med_q[1] <= '0;
			med_q[2] <= '0;
		end else if (state_q == S_EVAL && hit) begin
			med_q[axis_q] <= cval_q;
		end
		if (out_load) begin
			out_data_q.median_x <= med_q[0];
			out_data_q.median_y <= med_q[1];
			out_data_q.median_z <= med_q[2];
			out_data_q.status   <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`PSAM_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "top: stray word")
	`PSAM_ASSERT(a_sweep_bound, (state_q == S_SWEEP) |-> (sweep_q <= n_q), "top: sweep past set")
	`PSAM_ASSERT(a_count_bound, cnt_q <= CNT_W'(MAX_POINTS), "top: point count above capacity")
	`PSAM_ASSERT(a_eval_counts, (state_q == S_EVAL) |-> (rcnt.le <= n_q), "top: rank count too big")

endmodule

### rtl/psam_ram.sv
// Generic simple dual port RAM, one write port, one registered read port.
// No dependencies.
module psam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/psam_rank.sv
// Shared signed compare unit with less-than and less-or-equal counters.
// Depends on psam_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psam_rank
	import psam_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rank_ctl_t ctl,
	input  coord_t    smp,
	input  coord_t    cand,
	output rank_cnt_t cnt
);

	cnt_t lt_q;
	cnt_t le_q;
	logic is_lt;
	logic is_eq;

	assign is_lt = smp < cand;
	assign is_eq = smp == cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl.clr) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl.smp_vld) begin
			lt_q <= lt_q + CNT_W'(is_lt);
			le_q <= le_q + CNT_W'(is_lt | is_eq);
		end
	end

	assign cnt.lt = lt_q;
	assign cnt.le = le_q;

	`PSAM_ASSERT(a_le_ge_lt, le_q >= lt_q, "rank: le count below lt count")

endmodule

### sim/axis_median_checker.sv
// Checker for the point set median block: watches both channels, predicts each result word.
// Depends on psam_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module axis_median_checker
	import psam_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        pending,
	output int        fail_count,
	output int        words_checked,
	output int        short_sets,
	output int        overflow_sets
);

	coord_t    point_store [3][MAX_POINTS];
	coord_t    scratch [MAX_POINTS];
	int        stored;
	logic      dropped;
	out_word_t expected_medians [$];

	function automatic coord_t axis_median(input int axis);
		int     i;
		int     j;
		coord_t key;
		for (i = 0; i < stored; i++) begin
			key = point_store[axis][i];
			j = i;
			while (j > 0 && scratch[j-1] > key) begin
				scratch[j] = scratch[j-1];
				j--;
			end
			scratch[j] = key;
		end
		return scratch[stored / 2];
	endfunction

	task automatic check_field(input string name, input coord_t want, input coord_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		out_word_t want;
		if (!arst_n) begin
			stored = 0;
			dropped = 1'b0;
			expected_medians.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (stored < MAX_POINTS) begin
					point_store[0][stored] = in_data.coord_x;
					point_store[1][stored] = in_data.coord_y;
					point_store[2][stored] = in_data.coord_z;
					stored++;
				end else begin
					dropped = 1'b1;
				end
				if (in_data.last_point) begin
					if (stored < MIN_SET) begin
						want = '{median_x: '0, median_y: '0, median_z: '0, status: ST_FEW};
						short_sets++;
					end else begin
						want.median_x = axis_median(0);
						want.median_y = axis_median(1);
						want.median_z = axis_median(2);
						want.status = dropped ? ST_OVER : ST_OK;
						if (dropped)
							overflow_sets++;
					end
					expected_medians.insert(expected_medians.size(), want);
					stored = 0;
					dropped = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				if (expected_medians.size() == 0) begin
					$error("result word with no closed set waiting, status %0d", out_data.status);
					fail_count++;
				end else begin
					want = expected_medians.pop_front();
					words_checked++;
					check_field("median_x", want.median_x, out_data.median_x);
					check_field("median_y", want.median_y, out_data.median_y);
					check_field("median_z", want.median_z, out_data.median_z);
					check_field("status", coord_t'(want.status), coord_t'(out_data.status));
				end
			end
			pending <= expected_medians.size();
		end
	end

endmodule

### sim/testbench.sv
// Testbench top for point_set_axis_median: clock, reset, point stream and result-side ready.
// Depends on psam_pkg, the block and axis_median_checker, which does all prediction.
`timescale 1ns / 1ps

module testbench;
	import psam_pkg::*;

	localparam coord_t C_MIN        = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t C_MAX        = ~C_MIN;
	localparam int     HOLD_CYCLES  = 5000;
	localparam int     DRAIN_CYCLES = 200;

	typedef enum logic [1:0] {PH_SLOW_RX, PH_SLOW_TX, PH_HOLD, PH_FULL_RATE} load_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	load_phase_t phase = PH_SLOW_RX;
	int          pending;
	int          fail_count;
	int          words_checked;
	int          short_sets;
	int          overflow_sets;
	int          points_sent = 0;
	int          sets_sent = 0;

	point_set_axis_median uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	axis_median_checker median_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.pending       (pending),
		.fail_count    (fail_count),
		.words_checked (words_checked),
		.short_sets    (short_sets),
		.overflow_sets (overflow_sets)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(64'd50_000_000);
		$display("== FAIL ==");
		$finish;
	end

	function automatic int tx_idle_pct();
		case (phase)
			PH_SLOW_RX: return 18;
			PH_SLOW_TX: return 64;
			default:    return 0;
		endcase
	endfunction

	function automatic int rx_idle_pct();
		case (phase)
			PH_SLOW_RX: return 64;
			PH_SLOW_TX: return 18;
			default:    return 0;
		endcase
	endfunction

	function automatic coord_t corner(input int k);
		case (k % 6)
			0:       return C_MIN;
			1:       return C_MAX;
			2:       return '0;
			3:       return -1;
			4:       return 1;
			default: return C_MIN + 1;
		endcase
	endfunction

	// mix full-range values with a narrow band, so that ties are common
	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0:       return coord_t'(int'($urandom_range(8)) - 4);
			1:       return corner($urandom_range(3));
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic int set_size();
		if ($urandom_range(99) < 12)
			return $urandom_range(2, 1);
		return $urandom_range(24, 3);
	endfunction

	task automatic send_point(input coord_t x, input coord_t y, input coord_t z, input logic last);
		logic took;
		while ($urandom_range(99) < tx_idle_pct()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{coord_x: x, coord_y: y, coord_z: z, last_point: last};
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		points_sent++;
		if (last)
			sets_sent++;
	endtask

	task automatic send_set(input int n);
		int k;
		for (k = 0; k < n; k++)
			send_point(rand_coord(), rand_coord(), rand_coord(), k == n - 1);
	endtask

	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == PH_HOLD && !hold_done) begin
				// hold off so that the next set loads and its result waits in the done state
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct());
		end
	end

	initial begin : stimulus
		int n;
		int i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sets of one to six points with x and y built from the coordinate extremes
		for (n = 1; n <= 6; n++)
			for (i = 0; i < n; i++)
				send_point(corner(i + n), (n == 6) ? corner(i % 2) : corner(5 * i + n),
					coord_t'(n - i), i == n - 1);

		while (points_sent < 150)
			send_set(set_size());
		phase <= PH_SLOW_TX;
		while (points_sent < 290)
			send_set(set_size());

		// drain every result before the receiver stalls
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);

		phase <= PH_HOLD;
		while (points_sent < 340)
			send_set(set_size());
		phase <= PH_FULL_RATE;
		send_set(MAX_POINTS);
		send_set(MAX_POINTS + 2);
		while (points_sent < 860)
			send_set(set_size());
		in_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d points in %0d sets; %0d result words checked.",
			points_sent, sets_sent, words_checked);
		$display("Sets under three points: %0d, sets over capacity: %0d, mismatches: %0d.",
			short_sets, overflow_sets, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
